FILE: hw/rtl/hcb_pkg.sv
// hcb_pkg: sizes, types and FSM states of the Huffman code builder.
// No dependencies; imported by every module of the block.
package hcb_pkg;

    localparam int MAX_LEAVES   = 16;
    localparam int WEIGHT_BITS  = 16;
    localparam int NODE_SLOTS   = 2 * MAX_LEAVES;
    localparam int NODE_IDX_W   = $clog2(NODE_SLOTS);
    localparam int LEAF_CNT_W   = $clog2(MAX_LEAVES + 1);
    localparam int NODE_W       = WEIGHT_BITS + $clog2(MAX_LEAVES);
    // compare width: one bit above any node weight so the empty mark beats any sum
    localparam int CMP_W        = NODE_W + 1;

    // fixed port widths
    localparam int IN_WEIGHT_W  = 16;
    localparam int OUT_WEIGHT_W = 16;
    localparam int LEAF_IDX_W   = 4;
    localparam int CODE_W       = 15;
    localparam int CODE_LEN_W   = 4;

    typedef logic [NODE_IDX_W-1:0] node_idx_t;
    typedef logic [NODE_W-1:0]     node_w_t;
    typedef logic [LEAF_CNT_W-1:0] leaf_cnt_t;
    typedef logic [CMP_W-1:0]      cmp_w_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_MERGE_L,
        ST_MERGE_R,
        ST_WALK
    } hcb_state_t;

    // write side of the node store
    typedef struct packed {
        logic      weight_we;
        node_idx_t weight_addr;
        node_w_t   weight_data;
        logic      link_we;
        node_idx_t link_addr;
        node_idx_t link_parent;
        logic      link_right;
        logic      links_clr;
    } hcb_store_cmd_t;

    // read side of the node store
    typedef struct packed {
        node_w_t   weight;
        logic      has_parent;
        node_idx_t parent;
        logic      right;
    } hcb_store_rd_t;

endpackage

FILE: hw/rtl/huffman_code_builder.sv
// huffman_code_builder: top level; loader, merge sequencer and code walker.
// Load: one weight per cycle while leaf_stall is low. Build: merge node i, i = n+1 .. 2n-1,
//   scans nodes 1 .. i-1, writes sum and left link, then right link. Emit: each leaf walks
//   to the root, plus any output stall. leaf_stall is high from the final transaction until
//   the last code is registered; the last result may wait while the next set loads.
// Reset (rst_n, async low): idle in load state, leaf count zero, no result pending.
// Depends on hcb_pkg, hcb_node_store, hcb_min2_scan.
module huffman_code_builder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // leaf weight channel
    input  logic                                 leaf_valid,
    output logic                                 leaf_stall,
    input  logic [hcb_pkg::IN_WEIGHT_W-1:0]      weight,
    input  logic                                 final_leaf,
    // code channel
    output logic                                 code_valid,
    input  logic                                 code_stall,
    output logic [hcb_pkg::LEAF_IDX_W-1:0]       leaf_index,
    output logic [hcb_pkg::OUT_WEIGHT_W-1:0]     leaf_weight,
    output logic [hcb_pkg::CODE_W-1:0]           code_bits,
    output logic [hcb_pkg::CODE_LEN_W-1:0]       code_length,
    output logic                                 last_code
);
    import hcb_pkg::*;

    hcb_state_t state_reg, state_next;

    leaf_cnt_t count_reg, count_next;   // leaves held in the current set
    leaf_cnt_t n_reg, n_next;           // leaves in the set being built
    node_idx_t node_reg, node_next;     // merge node being formed
    node_idx_t scan_reg, scan_next;     // node under scan
    leaf_cnt_t leaf_reg, leaf_next;     // leaf being coded, from 1
    node_idx_t cur_reg, cur_next;       // walk position
    logic [CODE_W-1:0]     bits_reg, bits_next;
    logic [CODE_LEN_W-1:0] len_reg, len_next;

    logic                    out_valid_reg, out_valid_next;
    logic [LEAF_IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [OUT_WEIGHT_W-1:0] out_w_reg, out_w_next;
    logic [CODE_W-1:0]       out_bits_reg, out_bits_next;
    logic [CODE_LEN_W-1:0]   out_len_reg, out_len_next;
    logic                    out_last_reg, out_last_next;

    hcb_store_cmd_t cmd;
    hcb_store_rd_t  rd;
    node_idx_t      weight_raddr;
    node_idx_t      link_raddr;

    logic      scan_clr;
    logic      scan_en;
    node_idx_t s1, s2;
    node_w_t   merge_sum;

    logic      in_take;
    logic      out_free;
    logic      room;
    leaf_cnt_t count_inc;
    node_idx_t last_node;
    node_idx_t node_prev;
    logic      scan_done;
    logic      walk_done;
    logic      leaf_is_last;

    hcb_node_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .weight_raddr (weight_raddr),
        .link_raddr   (link_raddr),
        .rd           (rd)
    );

    hcb_min2_scan u_scan (
        .clk      (clk),
        .clr      (scan_clr),
        .en       (scan_en),
        .cand_w   (rd.weight),
        .cand_idx (scan_reg),
        .s1       (s1),
        .s2       (s2),
        .sum      (merge_sum)
    );

    // --- status terms -------------------------------------------------------
    assign leaf_stall   = (state_reg != ST_LOAD);
    assign in_take      = leaf_valid && !leaf_stall;
    assign out_free     = !out_valid_reg || !code_stall;
    assign room         = (count_reg < LEAF_CNT_W'(MAX_LEAVES));
    // extra weights past MAX_LEAVES are dropped
    assign count_inc    = room ? (count_reg + 1'b1) : count_reg;
    // root index 2n-1
    assign last_node    = NODE_IDX_W'({n_reg, 1'b0} - (LEAF_CNT_W + 1)'(1));
    assign node_prev    = node_reg - 1'b1;
    assign scan_done    = (scan_reg == node_prev);
    assign walk_done    = !rd.has_parent;
    assign leaf_is_last = (leaf_reg == n_reg);

    // scan reads node k; walk reads the leaf weight and the link of the current node
    assign weight_raddr = (state_reg == ST_WALK) ? NODE_IDX_W'(leaf_reg) : scan_reg;
    assign link_raddr   = (state_reg == ST_WALK) ? cur_reg : scan_reg;

    // --- next state ---------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_take && final_leaf)
                begin
                    // a single leaf has no merges
                    state_next = (count_inc == LEAF_CNT_W'(1)) ? ST_WALK : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_MERGE_L;
                end
            end
            ST_MERGE_L:
            begin
                state_next = ST_MERGE_R;
            end
            ST_MERGE_R:
            begin
                state_next = (node_reg == last_node) ? ST_WALK : ST_SCAN;
            end
            ST_WALK:
            begin
                if (walk_done && out_free && leaf_is_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // --- datapath and store control -----------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        n_next         = n_reg;
        node_next      = node_reg;
        scan_next      = scan_reg;
        leaf_next      = leaf_reg;
        cur_next       = cur_reg;
        bits_next      = bits_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && code_stall;
        out_idx_next   = out_idx_reg;
        out_w_next     = out_w_reg;
        out_bits_next  = out_bits_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        scan_clr       = 1'b0;
        scan_en        = 1'b0;
        cmd            = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_take)
                begin
                    count_next      = count_inc;
                    cmd.weight_we   = room;
                    cmd.weight_addr = NODE_IDX_W'(count_inc);
                    cmd.weight_data = NODE_W'(weight[WEIGHT_BITS-1:0]);
                    if (final_leaf)
                    begin
                        count_next    = '0;
                        n_next        = count_inc;
                        node_next     = NODE_IDX_W'(count_inc) + 1'b1;
                        scan_next     = NODE_IDX_W'(1);
                        leaf_next     = LEAF_CNT_W'(1);
                        cur_next      = NODE_IDX_W'(1);
                        bits_next     = '0;
                        len_next      = '0;
                        cmd.links_clr = 1'b1;
                        scan_clr      = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // only nodes not yet merged take part
                scan_en   = !rd.has_parent;
                scan_next = scan_reg + 1'b1;
            end
            ST_MERGE_L:
            begin
                // smaller node becomes the left child
                cmd.weight_we   = 1'b1;
                cmd.weight_addr = node_reg;
                cmd.weight_data = merge_sum;
                cmd.link_we     = 1'b1;
                cmd.link_addr   = s1;
                cmd.link_parent = node_reg;
                cmd.link_right  = 1'b0;
            end
            ST_MERGE_R:
            begin
                cmd.link_we     = 1'b1;
                cmd.link_addr   = s2;
                cmd.link_parent = node_reg;
                cmd.link_right  = 1'b1;
                scan_clr        = 1'b1;
                node_next       = node_reg + 1'b1;
                scan_next       = NODE_IDX_W'(1);
            end
            ST_WALK:
            begin
                if (!walk_done)
                begin
                    // leaf-side bit lands lowest, root-side bit ends up highest
                    bits_next = bits_reg | (CODE_W'(rd.right) << len_reg);
                    len_next  = len_reg + 1'b1;
                    cur_next  = rd.parent;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = LEAF_IDX_W'(leaf_reg - 1'b1);
                    out_w_next     = rd.weight[OUT_WEIGHT_W-1:0];
                    out_bits_next  = bits_reg;
                    out_len_next   = len_reg;
                    out_last_next  = leaf_is_last;
                    leaf_next      = leaf_reg + 1'b1;
                    cur_next       = NODE_IDX_W'(leaf_reg + 1'b1);
                    bits_next      = '0;
                    len_next       = '0;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // --- registers ----------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        node_reg     <= node_next;
        scan_reg     <= scan_next;
        leaf_reg     <= leaf_next;
        cur_reg      <= cur_next;
        bits_reg     <= bits_next;
        len_reg      <= len_next;
        out_idx_reg  <= out_idx_next;
        out_w_reg    <= out_w_next;
        out_bits_reg <= out_bits_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign code_valid  = out_valid_reg;
    assign leaf_index  = out_idx_reg;
    assign leaf_weight = out_w_reg;
    assign code_bits   = out_bits_reg;
    assign code_length = out_len_reg;
    assign last_code   = out_last_reg;

endmodule

FILE: hw/rtl/hcb_node_store.sv
// hcb_node_store: node weights, parent links and parent-valid bits of the tree.
// Depends on hcb_pkg.
module hcb_node_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hcb_pkg::hcb_store_cmd_t cmd,
    input  hcb_pkg::node_idx_t      weight_raddr,
    input  hcb_pkg::node_idx_t      link_raddr,
    output hcb_pkg::hcb_store_rd_t  rd
);
    import hcb_pkg::*;

    node_w_t                   weight_reg [NODE_SLOTS];
    node_idx_t                 parent_reg [NODE_SLOTS];
    logic [NODE_SLOTS-1:0]     right_reg;
    logic [NODE_SLOTS-1:0]     has_parent_reg;

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.weight_we)
        begin
            weight_reg[cmd.weight_addr] <= cmd.weight_data;
        end
        if (cmd.link_we)
        begin
            parent_reg[cmd.link_addr] <= cmd.link_parent;
            right_reg[cmd.link_addr]  <= cmd.link_right;
        end
    end

    // parent-valid bits stand in for clearing the parent array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_parent_reg <= '0;
        end
        else if (cmd.links_clr)
        begin
            has_parent_reg <= '0;
        end
        else if (cmd.link_we)
        begin
            has_parent_reg[cmd.link_addr] <= 1'b1;
        end
    end

    assign rd.weight     = weight_reg[weight_raddr];
    assign rd.has_parent = has_parent_reg[link_raddr];
    assign rd.parent     = parent_reg[link_raddr];
    assign rd.right      = right_reg[link_raddr];

endmodule

FILE: hw/rtl/hcb_min2_scan.sv
// hcb_min2_scan: shared compare unit, tracks the two smallest weights of a scan.
// Depends on hcb_pkg. Strict less-than, so ties keep the earlier index.
module hcb_min2_scan (
    input  logic               clk,
    input  logic               clr,
    input  logic               en,
    input  hcb_pkg::node_w_t   cand_w,
    input  hcb_pkg::node_idx_t cand_idx,
    output hcb_pkg::node_idx_t s1,
    output hcb_pkg::node_idx_t s2,
    output hcb_pkg::node_w_t   sum
);
    import hcb_pkg::*;

    cmp_w_t    w1_reg, w1_next;
    cmp_w_t    w2_reg, w2_next;
    node_idx_t s1_reg, s1_next;
    node_idx_t s2_reg, s2_next;
    cmp_w_t    cand_ext;
    cmp_w_t    sum_full;

    assign cand_ext = CMP_W'(cand_w);

    always_comb
    begin
        w1_next = w1_reg;
        w2_next = w2_reg;
        s1_next = s1_reg;
        s2_next = s2_reg;
        if (clr)
        begin
            w1_next = '1;
            w2_next = '1;
        end
        else if (en)
        begin
            if (cand_ext < w1_reg)
            begin
                w2_next = w1_reg;
                s2_next = s1_reg;
                w1_next = cand_ext;
                s1_next = cand_idx;
            end
            else if (cand_ext < w2_reg)
            begin
                w2_next = cand_ext;
                s2_next = cand_idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg <= w1_next;
        w2_reg <= w2_next;
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign sum_full = w1_reg + w2_reg;
    assign sum      = sum_full[NODE_W-1:0];
    assign s1       = s1_reg;
    assign s2       = s2_reg;

endmodule

FILE: sim/huffman_code_builder_tb.sv
// huffman_code_builder_tb: self-checking bench for the Huffman code builder.
// Drives leaf weight sets, predicts every code word and compares the code channel.
// Depends on hcb_pkg and huffman_code_builder.
`timescale 1ns / 100ps

module huffman_code_builder_tb;

    import hcb_pkg::*;

    localparam int PLAN_ITEMS  = 360;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 800;   // longer than a full 16-leaf build plus emit
    localparam int TAIL_CYCLES = 40;

    // one leaf transaction as queued for the driver; drain marks a sender pause
    typedef struct packed {
        logic [IN_WEIGHT_W-1:0] weight;
        logic                   final_leaf;
        logic                   drain;
    } leaf_item_t;

    // one code transaction as predicted
    typedef struct packed {
        logic [LEAF_IDX_W-1:0]   leaf_index;
        logic [OUT_WEIGHT_W-1:0] leaf_weight;
        logic [CODE_W-1:0]       code_bits;
        logic [CODE_LEN_W-1:0]   code_length;
        logic                    last_code;
    } code_word_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     leaf_valid = 1'b0;
    logic                     leaf_stall;
    logic [IN_WEIGHT_W-1:0]   weight = '0;
    logic                     final_leaf = 1'b0;
    logic                     code_valid;
    logic                     code_stall = 1'b0;
    logic [LEAF_IDX_W-1:0]    leaf_index;
    logic [OUT_WEIGHT_W-1:0]  leaf_weight;
    logic [CODE_W-1:0]        code_bits;
    logic [CODE_LEN_W-1:0]    code_length;
    logic                     last_code;

    huffman_code_builder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .leaf_valid  (leaf_valid),
        .leaf_stall  (leaf_stall),
        .weight      (weight),
        .final_leaf  (final_leaf),
        .code_valid  (code_valid),
        .code_stall  (code_stall),
        .leaf_index  (leaf_index),
        .leaf_weight (leaf_weight),
        .code_bits   (code_bits),
        .code_length (code_length),
        .last_code   (last_code)
    );

    always #5 clk = ~clk;

    // stimulus and expectations
    leaf_item_t  leaf_plan[$];
    code_word_t  codes_due[$];
    int          planned_leaves = 0;
    int          leaves_taken = 0;   // accepted leaf transactions
    bit          leaf_taken_now = 1'b0;
    bit          failed = 1'b0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // private copy of the tree built by the block
    node_w_t     tree_weight [NODE_SLOTS];
    node_idx_t   tree_parent [NODE_SLOTS];
    node_idx_t   tree_left   [NODE_SLOTS];
    int          held_leaves = 0;

    // Load one leaf; on the closing leaf build the tree and queue one code per leaf.
    task automatic predict_codes(input logic [IN_WEIGHT_W-1:0] w, input logic fin);
        int          n;
        int          c;
        int          f;
        int          len;
        cmp_w_t      best1;
        cmp_w_t      best2;
        int          s1;
        int          s2;
        logic [CODE_W-1:0] bits;
        code_word_t  cw;
        // leaves past the array size are dropped, their final flag still counts
        if (held_leaves < MAX_LEAVES) begin
            held_leaves++;
            tree_weight[held_leaves] = node_w_t'(w);
        end
        if (!fin)
            return;
        n = held_leaves;
        for (int i = 1; i <= 2 * n - 1; i++) begin
            tree_parent[i] = '0;
            tree_left[i]   = '0;
            if (i > n)
                tree_weight[i] = '0;
        end
        // each merge: two lightest free nodes, strict less-than so ties keep lower index
        for (int i = n + 1; i <= 2 * n - 1; i++) begin
            best1 = '1;
            best2 = '1;
            s1 = 0;
            s2 = 0;
            for (int k = 1; k < i; k++) begin
                if (tree_parent[k] == '0) begin
                    if ({1'b0, tree_weight[k]} < best1) begin
                        best2 = best1;
                        s2    = s1;
                        best1 = {1'b0, tree_weight[k]};
                        s1    = k;
                    end
                    else if ({1'b0, tree_weight[k]} < best2) begin
                        best2 = {1'b0, tree_weight[k]};
                        s2    = k;
                    end
                end
            end
            tree_parent[s1] = node_idx_t'(i);
            tree_parent[s2] = node_idx_t'(i);
            tree_left[i]    = node_idx_t'(s1);
            tree_weight[i]  = tree_weight[s1] + tree_weight[s2];
        end
        // walk leaf to root; the leaf-side bit lands at bit 0, root-side ends up on top
        for (int leaf = 1; leaf <= n; leaf++) begin
            bits = '0;
            len  = 0;
            c    = leaf;
            f    = tree_parent[c];
            while (f != 0) begin
                if (tree_left[f] != node_idx_t'(c))
                    bits[len] = 1'b1;
                len++;
                c = f;
                f = tree_parent[f];
            end
            cw.leaf_index  = LEAF_IDX_W'(leaf - 1);
            cw.leaf_weight = tree_weight[leaf][OUT_WEIGHT_W-1:0];
            cw.code_bits   = bits;
            cw.code_length = CODE_LEN_W'(len);
            cw.last_code   = (leaf == n);
            codes_due.push_back(cw);
        end
        held_leaves = 0;
    endtask

    // Idle percentage per side: first thirds sender 9 / receiver 70, then swapped,
    // then no idling at all.
    function automatic int unsigned idle_pct(input bit sender_side);
        if (leaves_taken < planned_leaves / 3)
            return sender_side ? 9 : 70;
        if (leaves_taken < 2 * planned_leaves / 3)
            return sender_side ? 70 : 9;
        return 0;
    endfunction

    // Leaf driver: a new transaction only once the current one was accepted.
    // A drain marker holds valid low until every predicted code has come back.
    always @(negedge clk) begin
        leaf_item_t nxt;
        if (rst_n) begin
            if (!leaf_valid || leaf_taken_now) begin
                leaf_taken_now = 1'b0;
                if (leaf_plan.size() != 0 && leaf_plan[0].drain && codes_due.size() == 0)
                    void'(leaf_plan.pop_front());
                if (leaf_plan.size() != 0 && !leaf_plan[0].drain &&
                    $urandom_range(99) >= idle_pct(1'b1)) begin
                    nxt = leaf_plan.pop_front();
                    leaf_valid <= 1'b1;
                    weight     <= nxt.weight;
                    final_leaf <= nxt.final_leaf;
                end
                else begin
                    leaf_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off halfway through, so the builder fills and stalls leaves.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!hold_done && leaves_taken >= planned_leaves / 2) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // Code channel stall
    always @(negedge clk) begin
        if (rst_n)
            code_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct(1'b0));
    end

    // Monitor: predict on each accepted leaf, check each accepted code word.
    always @(posedge clk) begin
        code_word_t exp_cw;
        if (rst_n) begin
            if (leaf_valid && !leaf_stall) begin
                predict_codes(weight, final_leaf);
                leaves_taken++;
                leaf_taken_now = 1'b1;
            end
            if (code_valid && !code_stall) begin
                if (codes_due.size() == 0) begin
                    $error("code transaction with none expected: leaf_index %0d", leaf_index);
                    failed = 1'b1;
                end
                else begin
                    exp_cw = codes_due.pop_front();
                    if (leaf_index !== exp_cw.leaf_index) begin
                        $error("leaf_index expected %0d got %0d", exp_cw.leaf_index, leaf_index);
                        failed = 1'b1;
                    end
                    if (leaf_weight !== exp_cw.leaf_weight) begin
                        $error("leaf_weight expected %0d got %0d",
                               exp_cw.leaf_weight, leaf_weight);
                        failed = 1'b1;
                    end
                    if (code_bits !== exp_cw.code_bits) begin
                        $error("code_bits expected %h got %h", exp_cw.code_bits, code_bits);
                        failed = 1'b1;
                    end
                    if (code_length !== exp_cw.code_length) begin
                        $error("code_length expected %0d got %0d",
                               exp_cw.code_length, code_length);
                        failed = 1'b1;
                    end
                    if (last_code !== exp_cw.last_code) begin
                        $error("last_code expected %0d got %0d", exp_cw.last_code, last_code);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic plan_leaf(input logic [IN_WEIGHT_W-1:0] w, input logic fin);
        leaf_item_t it;
        it.weight     = w;
        it.final_leaf = fin;
        it.drain      = 1'b0;
        leaf_plan.push_back(it);
        planned_leaves++;
    endtask

    initial begin
        int         set_size;
        int         flavor;
        logic [IN_WEIGHT_W-1:0] w;
        leaf_item_t pause;

        // directed: single leaf at both weight extremes (empty code)
        plan_leaf(16'h0000, 1'b1);
        plan_leaf(16'hFFFF, 1'b1);
        // two equal leaves: tie goes to the lower index
        plan_leaf(16'd7, 1'b0);
        plan_leaf(16'd7, 1'b1);
        // extremes mixed
        plan_leaf(16'hFFFF, 1'b0);
        plan_leaf(16'h0000, 1'b0);
        plan_leaf(16'h8000, 1'b1);
        // 1,1,2,4..16384 gives a 15-deep chain; 17th leaf is dropped but closes the set
        plan_leaf(16'd1, 1'b0);
        for (int i = 0; i < 15; i++)
            plan_leaf(IN_WEIGHT_W'(1 << i), 1'b0);
        plan_leaf(16'hABCD, 1'b1);

        // sender pause until every code is back
        pause = '0;
        pause.drain = 1'b1;
        leaf_plan.push_back(pause);

        // random sets, a few overfull
        while (planned_leaves < PLAN_ITEMS) begin
            set_size = ($urandom_range(9) == 0) ? $urandom_range(20, 17)
                                                : $urandom_range(16, 1);
            flavor = $urandom_range(3);
            for (int j = 0; j < set_size; j++) begin
                case (flavor)
                    0:       w = IN_WEIGHT_W'($urandom);
                    1:       w = IN_WEIGHT_W'($urandom_range(3));       // many ties
                    2:       w = IN_WEIGHT_W'($urandom_range(65535, 65000));
                    default: w = IN_WEIGHT_W'(1 << $urandom_range(15));
                endcase
                plan_leaf(w, j == set_size - 1);
            end
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (leaf_plan.size() != 0 || leaf_valid)
            @(posedge clk);
        while (codes_due.size() != 0)
            @(posedge clk);
        // nothing further may appear on the code channel
        repeat (TAIL_CYCLES) @(posedge clk);

        if (!failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
